[rtl/core/mafs_pkg.sv]
// mafs_pkg: shared types, codes and header lookup tables for the frame sync block
// used by every module under rtl/core
`timescale 1ns / 1ps
`default_nettype none

package mafs_pkg;

    localparam int NUM_W  = 26;
    localparam int DEN_W  = 16;
    localparam int BODY_W = 12;
    localparam int PROD_W = 20;

    localparam logic [BODY_W-1:0] BODY_MAX  = 12'd4095;
    localparam logic [7:0]        SYNC_BYTE = 8'hFF;
    localparam logic [2:0]        SYNC_TOP  = 3'b111;
    localparam logic [6:0]        SCALE_K   = 7'd125;

    localparam logic [1:0] VER_25  = 2'd0;
    localparam logic [1:0] VER_RES = 2'd1;
    localparam logic [1:0] VER_2   = 2'd2;
    localparam logic [1:0] VER_1   = 2'd3;

    localparam logic [1:0] LAY_RES = 2'd0;
    localparam logic [1:0] LAY_3   = 2'd1;
    localparam logic [1:0] LAY_2   = 2'd2;
    localparam logic [1:0] LAY_1   = 2'd3;

    typedef struct packed {
        logic search;
        logic hdr3;
        logic hdr4;
        logic skip;
        logic clear;
        logic calc_mul;
        logic calc_scale;
        logic div_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic sync_hit;
        logic hdr_ok;
        logic skip_done;
        logic div_done;
        logic body_zero;
        logic out_free;
    } t_stat;

    localparam logic [8:0] RATE_V1_L1 [0:15] = '{0, 32, 64, 96, 128, 160, 192, 224,
                                                 256, 288, 320, 352, 384, 416, 448, 0};
    localparam logic [8:0] RATE_V1_L2 [0:15] = '{0, 32, 48, 56, 64, 80, 96, 112,
                                                 128, 160, 192, 224, 256, 320, 384, 0};
    localparam logic [8:0] RATE_V1_L3 [0:15] = '{0, 32, 40, 48, 56, 64, 80, 96,
                                                 112, 128, 160, 192, 224, 256, 320, 0};
    localparam logic [8:0] RATE_V2_L1 [0:15] = '{0, 32, 48, 56, 64, 80, 96, 112,
                                                 128, 144, 160, 176, 192, 224, 256, 0};
    localparam logic [8:0] RATE_V2_L23 [0:15] = '{0, 8, 16, 24, 32, 40, 48, 56,
                                                  64, 80, 96, 112, 128, 144, 160, 0};
    localparam logic [15:0] SRATE_V1 [0:3]  = '{44100, 48000, 32000, 1};
    localparam logic [15:0] SRATE_V2 [0:3]  = '{22050, 24000, 16000, 1};
    localparam logic [15:0] SRATE_V25 [0:3] = '{11025, 12000, 8000, 1};

    function automatic logic [8:0] f_bitrate(input logic [1:0] ver, input logic [1:0] lay,
                                             input logic [3:0] idx);
        logic [8:0] r;
        r = 9'd0;
        if (ver == VER_1) begin
            if (lay == LAY_1) r = RATE_V1_L1[idx];
            else if (lay == LAY_2) r = RATE_V1_L2[idx];
            else if (lay == LAY_3) r = RATE_V1_L3[idx];
        end else if (ver == VER_25 || ver == VER_2) begin
            if (lay == LAY_1) r = RATE_V2_L1[idx];
            else if (lay == LAY_2 || lay == LAY_3) r = RATE_V2_L23[idx];
        end
        return r;
    endfunction

    function automatic logic [15:0] f_srate(input logic [1:0] ver, input logic [1:0] idx);
        logic [15:0] r;
        case (ver)
            VER_1:   r = SRATE_V1[idx];
            VER_2:   r = SRATE_V2[idx];
            VER_25:  r = SRATE_V25[idx];
            default: r = 16'd1;
        endcase
        return r;
    endfunction

    function automatic logic [10:0] f_samples(input logic [1:0] ver, input logic [1:0] lay);
        logic [10:0] r;
        if (ver == VER_RES || lay == LAY_RES) r = 11'd0;
        else if (lay == LAY_1) r = 11'd384;
        else if (lay == LAY_2) r = 11'd1152;
        else if (ver == VER_1) r = 11'd1152;
        else r = 11'd576;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mafs_div.sv]
// mafs_div: restoring divider, one quotient bit per cycle
// depends on mafs_pkg for operand widths
`timescale 1ns / 1ps
`default_nettype none

module mafs_div
    import mafs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quo,
    output logic                  o_done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        trial   = shifted - {1'b0, r_den};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem = '0;
            n_quo = i_num;
            n_cnt = CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            if (!trial[DEN_W]) begin
                n_rem = trial[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) r_den <= i_den;
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

[rtl/core/mafs_dp.sv]
// mafs_dp: byte offset, header capture, locks, size arithmetic and output register
// depends on mafs_pkg and mafs_div
`timescale 1ns / 1ps
`default_nettype none

module mafs_dp
    import mafs_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [7:0]        i_data_byte,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_ready,
    output t_stat                  o_stat,
    output logic                   o_valid,
    output logic [31:0]            o_frame_offset,
    output logic [31:0]            o_header_word,
    output logic [1:0]             o_version_code,
    output logic [1:0]             o_layer_code,
    output logic [8:0]             o_bitrate_kbps,
    output logic [15:0]            o_sample_rate_hz,
    output logic [10:0]            o_samples_per_frame,
    output logic                   o_padding_bit,
    output logic [BODY_W-1:0]      o_frame_body_bytes
);

    logic [OFFSET_BITS-1:0] r_offset, r_start;
    logic                   r_prev_ff;
    logic [23:0]            r_hdr;
    logic [BODY_W-1:0]      r_skip;
    logic [2:0]             r_lock_ver, r_lock_lay, n_lock_ver, n_lock_lay;

    logic [31:0]            r_word;
    logic [31:0]            r_fstart;
    logic [8:0]             r_br;
    logic [15:0]            r_sr;
    logic [10:0]            r_spf;
    logic [PROD_W-1:0]      r_prod;
    logic [NUM_W-1:0]       r_num;

    logic                   r_ovalid;

    logic [31:0]            word;
    logic [1:0]             ver, lay;
    logic                   ok_ver, ok_all;
    logic                   sync_hit;
    logic [NUM_W-1:0]       scaled;
    logic [NUM_W-1:0]       quo;
    logic                   div_done;
    logic [NUM_W:0]         body_sum;
    logic [2:0]             pad_add;
    logic [BODY_W-1:0]      body;
    logic                   out_free;

    mafs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_sr),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    assign word     = {r_hdr, i_data_byte};
    assign ver      = word[20:19];
    assign lay      = word[18:17];
    assign sync_hit = r_prev_ff && (i_data_byte[7:5] == SYNC_TOP);

    always_comb begin
        ok_ver     = !r_lock_ver[2] || (r_lock_ver[1:0] == ver);
        ok_all     = ok_ver && (!r_lock_lay[2] || (r_lock_lay[1:0] == lay));
        n_lock_ver = r_lock_ver[2] ? r_lock_ver : {1'b1, ver};
        n_lock_lay = r_lock_lay;
        if (ok_ver && !r_lock_lay[2]) n_lock_lay = {1'b1, lay};
    end

    // scaled numerator, body size from quotient, padding and saturation (zero for a reserved layer), output-free flag
    always_comb begin
        scaled   = NUM_W'(r_prod) * NUM_W'(SCALE_K);
        pad_add  = (r_word[18:17] == LAY_1) ? {r_word[9], 2'b00} : {2'b00, r_word[9]};
        body_sum = {1'b0, quo} + (NUM_W + 1)'(pad_add);
        if (r_word[18:17] == LAY_RES) body = '0;
        else if (body_sum > (NUM_W + 1)'(BODY_MAX)) body = BODY_MAX;
        else body = body_sum[BODY_W-1:0];
        out_free = !r_ovalid || i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_start    <= '0;
            r_prev_ff  <= 1'b0;
            r_hdr      <= '0;
            r_skip     <= '0;
            r_lock_ver <= '0;
            r_lock_lay <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cmd.search || i_cmd.hdr3 || i_cmd.hdr4 || i_cmd.skip) begin
                r_offset <= r_offset + 1'b1;
            end
            if (i_cmd.search) begin
                if (sync_hit) begin
                    r_start   <= r_offset - 1'b1;
                    r_hdr     <= {8'h00, SYNC_BYTE, i_data_byte};
                    r_prev_ff <= 1'b0;
                end else begin
                    r_prev_ff <= (i_data_byte == SYNC_BYTE);
                end
            end
            if (i_cmd.hdr3) r_hdr <= {r_hdr[15:0], i_data_byte};
            if (i_cmd.hdr4) begin
                r_lock_ver <= n_lock_ver;
                r_lock_lay <= n_lock_lay;
            end
            if (i_cmd.skip) r_skip <= r_skip - 1'b1;
            if (i_cmd.load_out) r_skip <= body;
            if (i_cmd.clear) begin
                r_offset   <= '0;
                r_start    <= '0;
                r_prev_ff  <= 1'b0;
                r_hdr      <= '0;
                r_skip     <= '0;
                r_lock_ver <= '0;
                r_lock_lay <= '0;
            end
            if (i_cmd.load_out) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hdr4) begin
            r_word   <= word;
            r_fstart <= 32'(r_start);
            r_br     <= f_bitrate(ver, lay, word[15:12]);
            r_sr     <= f_srate(ver, word[11:10]);
            r_spf    <= f_samples(ver, lay);
        end
        if (i_cmd.calc_mul) r_prod <= PROD_W'(r_spf) * PROD_W'(r_br);
        if (i_cmd.calc_scale) r_num <= scaled;
        if (i_cmd.load_out) begin
            o_frame_offset      <= r_fstart;
            o_header_word       <= r_word;
            o_version_code      <= r_word[20:19];
            o_layer_code        <= r_word[18:17];
            o_bitrate_kbps      <= r_br;
            o_sample_rate_hz    <= r_sr;
            o_samples_per_frame <= r_spf;
            o_padding_bit       <= r_word[9];
            o_frame_body_bytes  <= body;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_stat.sync_hit  = sync_hit;
    assign o_stat.hdr_ok    = ok_all;
    assign o_stat.skip_done = (r_skip == BODY_W'(1));
    assign o_stat.div_done  = div_done;
    assign o_stat.body_zero = (body == '0);
    assign o_stat.out_free  = out_free;

endmodule

`default_nettype wire

[rtl/core/mafs_ctrl.sv]
// mafs_ctrl: parse phase and size computation sequencer
// depends on mafs_pkg for command and status types
`timescale 1ns / 1ps
`default_nettype none

module mafs_ctrl
    import mafs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic  i_stream_end,
    input  wire t_stat i_stat,
    output logic       o_ready,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_SEARCH = 4'd0;
    localparam logic [3:0] S_HDR3   = 4'd1;
    localparam logic [3:0] S_HDR4   = 4'd2;
    localparam logic [3:0] S_SKIP   = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_SCALE  = 4'd5;
    localparam logic [3:0] S_DIVGO  = 4'd6;
    localparam logic [3:0] S_DIVW   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_last, n_last;
    logic       ready;
    logic       fire;

    always_comb begin
        ready = (r_state == S_SEARCH) || (r_state == S_HDR3) ||
                (r_state == S_HDR4) || (r_state == S_SKIP);
        fire  = ready && i_valid;
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.clear = fire && i_stream_end;
        case (r_state)
            S_SEARCH: begin
                o_cmd.search = fire;
                if (fire && !i_stream_end && i_stat.sync_hit) n_state = S_HDR3;
            end
            S_HDR3: begin
                o_cmd.hdr3 = fire;
                if (fire) n_state = i_stream_end ? S_SEARCH : S_HDR4;
            end
            S_HDR4: begin
                o_cmd.hdr4 = fire;
                if (fire) begin
                    n_last  = i_stream_end;
                    n_state = i_stat.hdr_ok ? S_MUL : S_SEARCH;
                end
            end
            S_SKIP: begin
                o_cmd.skip = fire;
                if (fire && (i_stream_end || i_stat.skip_done)) n_state = S_SEARCH;
            end
            S_MUL: begin
                o_cmd.calc_mul = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.calc_scale = 1'b1;
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (i_stat.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = (r_last || i_stat.body_zero) ? S_SEARCH : S_SKIP;
                end
            end
            default: n_state = S_SEARCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SEARCH;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    assign o_ready = ready;

endmodule

`default_nettype wire

[rtl/core/mpeg_audio_frame_sync.sv]
// mpeg_audio_frame_sync: top level of the audio frame sync and header parser
// depends on mafs_pkg, mafs_ctrl, mafs_dp (with mafs_div)
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_data_byte, i_stream_end
//   result    out        o_valid / i_ready   o_frame_offset .. o_frame_body_bytes
//
// one byte per cycle while searching, collecting a header or skipping a body
// after the fourth byte of an accepted header the input stalls through two multiply steps,
// a divider start, 26 divide steps, the done flag and the result load
// a finished result waits in the output register; bytes keep flowing meanwhile,
// only the next result load, and the input with it, waits for a free output register
// reset is synchronous, active low, and clears the offset, locks and phase
`timescale 1ns / 1ps
`default_nettype none

module mpeg_audio_frame_sync
    import mafs_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_stream_end,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [31:0]            o_frame_offset,
    output logic [31:0]            o_header_word,
    output logic [1:0]             o_version_code,
    output logic [1:0]             o_layer_code,
    output logic [8:0]             o_bitrate_kbps,
    output logic [15:0]            o_sample_rate_hz,
    output logic [10:0]            o_samples_per_frame,
    output logic                   o_padding_bit,
    output logic [11:0]            o_frame_body_bytes
);

    t_cmd  cmd;
    t_stat stat;

    mafs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_stream_end (i_stream_end),
        .i_stat       (stat),
        .o_ready      (o_ready),
        .o_cmd        (cmd)
    );

    mafs_dp #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_data_byte         (i_data_byte),
        .i_cmd               (cmd),
        .i_ready             (i_ready),
        .o_stat              (stat),
        .o_valid             (o_valid),
        .o_frame_offset      (o_frame_offset),
        .o_header_word       (o_header_word),
        .o_version_code      (o_version_code),
        .o_layer_code        (o_layer_code),
        .o_bitrate_kbps      (o_bitrate_kbps),
        .o_sample_rate_hz    (o_sample_rate_hz),
        .o_samples_per_frame (o_samples_per_frame),
        .o_padding_bit       (o_padding_bit),
        .o_frame_body_bytes  (o_frame_body_bytes)
    );

    a_no_load_while_accepting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> !cmd.load_out)
        else $error("result load while a byte is taken");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result load over a pending result");

    a_div_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |=> !o_ready)
        else $error("input open while divider runs");

    a_reserved_layer_no_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_layer_code == LAY_RES) |-> (o_frame_body_bytes == '0))
        else $error("body size for reserved layer");

endmodule

`default_nettype wire

[tb/tb.sv]
// tb: self-checking bench for mpeg_audio_frame_sync, predicts every header request
// depends on mafs_pkg and the rtl/core sources of the block
`timescale 1ns / 1ps

module tb;
    import mafs_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 64;
    localparam int LIVE_TARGET = 1650;
    localparam int BIG_BODY    = 160;

    localparam int KBPS [0:4][0:15] = '{
        '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
        '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
        '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
    };
    localparam int HZ [0:2][0:3] = '{
        '{44100, 48000, 32000, 1},
        '{22050, 24000, 16000, 1},
        '{11025, 12000, 8000, 1}
    };

    typedef enum logic [2:0] {ST_SCAN, ST_HDR3, ST_HDR4, ST_SKIP} t_scan_phase;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] word;
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [8:0]  kbps;
        logic [15:0] hz;
        logic [10:0] spf;
        logic        pad;
        logic [11:0] body;
    } t_frame_info;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stream_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_frame_offset;
    logic [31:0] o_header_word;
    logic [1:0]  o_version_code;
    logic [1:0]  o_layer_code;
    logic [8:0]  o_bitrate_kbps;
    logic [15:0] o_sample_rate_hz;
    logic [10:0] o_samples_per_frame;
    logic        o_padding_bit;
    logic [11:0] o_frame_body_bytes;

    t_scan_phase scan_st;
    bit          prev_ff;
    bit [23:0]   hdr_acc;
    bit [11:0]   skip_left;
    bit [31:0]   byte_pos;
    bit [31:0]   hdr_pos;
    bit          ver_locked;
    bit          lay_locked;
    bit [1:0]    ver_lock;
    bit [1:0]    lay_lock;

    t_frame_info headers_due[$];

    int n_bad = 0;
    int n_cycles = 0;
    int n_live = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int rx_hold = 0;

    mpeg_audio_frame_sync dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_byte        (i_data_byte),
        .i_stream_end       (i_stream_end),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_frame_offset     (o_frame_offset),
        .o_header_word      (o_header_word),
        .o_version_code     (o_version_code),
        .o_layer_code       (o_layer_code),
        .o_bitrate_kbps     (o_bitrate_kbps),
        .o_sample_rate_hz   (o_sample_rate_hz),
        .o_samples_per_frame(o_samples_per_frame),
        .o_padding_bit      (o_padding_bit),
        .o_frame_body_bytes (o_frame_body_bytes)
    );

    always #6 i_clk = ~i_clk;

    function automatic int kbps_of(bit [1:0] v, bit [1:0] l, bit [3:0] idx);
        if (v == VER_1) begin
            if (l == LAY_1) return KBPS[0][idx];
            if (l == LAY_2) return KBPS[1][idx];
            if (l == LAY_3) return KBPS[2][idx];
        end else if (v == VER_2 || v == VER_25) begin
            if (l == LAY_1) return KBPS[3][idx];
            if (l == LAY_2 || l == LAY_3) return KBPS[4][idx];
        end
        return 0;
    endfunction

    function automatic int hz_of(bit [1:0] v, bit [1:0] idx);
        case (v)
            VER_1:   return HZ[0][idx];
            VER_2:   return HZ[1][idx];
            VER_25:  return HZ[2][idx];
            default: return 1;
        endcase
    endfunction

    function automatic int spf_of(bit [1:0] v, bit [1:0] l);
        if (v == VER_RES || l == LAY_RES) return 0;
        if (l == LAY_1) return 384;
        if (l == LAY_2) return 1152;
        return (v == VER_1) ? 1152 : 576;
    endfunction

    function automatic int body_of(bit [31:0] w);
        longint unsigned n;
        bit [1:0] v;
        bit [1:0] l;
        v = w[20:19];
        l = w[18:17];
        if (l == LAY_RES) return 0;
        n = longint'(spf_of(v, l)) * (longint'(kbps_of(v, l, w[15:12])) * 1000) / 8;
        n = n / longint'(hz_of(v, w[11:10]));
        n += (l == LAY_1) ? longint'(w[9]) * 4 : longint'(w[9]);
        return (n > 4095) ? 4095 : int'(n);
    endfunction

    function automatic void clear_parser();
        scan_st = ST_SCAN;
        prev_ff = 1'b0;
        hdr_acc = '0;
        skip_left = '0;
        byte_pos = '0;
        hdr_pos = '0;
        ver_locked = 1'b0;
        lay_locked = 1'b0;
        ver_lock = '0;
        lay_lock = '0;
    endfunction

    function automatic void parse_byte(bit [7:0] b, bit last);
        bit [31:0]   w;
        t_frame_info f;
        bit          ok;
        case (scan_st)
            ST_SCAN: begin
                if (prev_ff && b[7:5] == SYNC_TOP) begin
                    hdr_pos = byte_pos - 1;
                    hdr_acc = {8'h00, SYNC_BYTE, b};
                    scan_st = ST_HDR3;
                    prev_ff = 1'b0;
                end else begin
                    prev_ff = (b == SYNC_BYTE);
                end
            end
            ST_HDR3: begin
                hdr_acc = {hdr_acc[15:0], b};
                scan_st = ST_HDR4;
            end
            ST_HDR4: begin
                w = {hdr_acc, b};
                ok = 1'b1;
                scan_st = ST_SCAN;
                prev_ff = 1'b0;
                if (!ver_locked) begin
                    ver_locked = 1'b1;
                    ver_lock = w[20:19];
                end else if (ver_lock != w[20:19]) begin
                    ok = 1'b0;
                end
                if (ok) begin
                    if (!lay_locked) begin
                        lay_locked = 1'b1;
                        lay_lock = w[18:17];
                    end else if (lay_lock != w[18:17]) begin
                        ok = 1'b0;
                    end
                end
                if (ok) begin
                    f.offset = hdr_pos;
                    f.word = w;
                    f.ver = w[20:19];
                    f.lay = w[18:17];
                    f.kbps = 9'(kbps_of(f.ver, f.lay, w[15:12]));
                    f.hz = 16'(hz_of(f.ver, w[11:10]));
                    f.spf = 11'(spf_of(f.ver, f.lay));
                    f.pad = w[9];
                    f.body = 12'(body_of(w));
                    headers_due = {headers_due, f};
                    skip_left = f.body;
                    if (skip_left != 0) scan_st = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (skip_left > 0) skip_left--;
                if (skip_left == 0) begin
                    scan_st = ST_SCAN;
                    prev_ff = 1'b0;
                end
            end
            default: begin
                scan_st = ST_SCAN;
                prev_ff = 1'b0;
            end
        endcase
        byte_pos++;
        if (last) clear_parser();
    endfunction

    function automatic string describe(t_frame_info f);
        return $sformatf({"off=%0d word=%h ver=%0d lay=%0d kbps=%0d hz=%0d",
                          " spf=%0d pad=%0d body=%0d"},
                         f.offset, f.word, f.ver, f.lay, f.kbps, f.hz, f.spf, f.pad, f.body);
    endfunction

    function automatic void count_bad(string msg);
        if (n_bad < 10) $display("%s", msg);
        n_bad++;
    endfunction

    always @(posedge i_clk) begin
        t_frame_info got;
        t_frame_info want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_frame_offset, o_header_word, o_version_code, o_layer_code,
                   o_bitrate_kbps, o_sample_rate_hz, o_samples_per_frame,
                   o_padding_bit, o_frame_body_bytes};
            if (headers_due.size() == 0) begin
                count_bad($sformatf("%0t unexpected header request: %s", $time, describe(got)));
            end else begin
                want = headers_due.pop_front();
                if (got !== want)
                    count_bad($sformatf("%0t header mismatch\n  expected %s\n  actual   %s",
                                        $time, describe(want), describe(got)));
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver side, long hold-offs counted down here
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else begin
                i_ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    task automatic send_byte(input bit [7:0] b, input bit last);
        n_live++;
        while ($urandom_range(99) < in_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_stream_end <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        parse_byte(b, last);
        @(negedge i_clk);
    endtask

    task automatic send_hdr(input bit [31:0] w, input bit last);
        send_byte(w[31:24], 1'b0);
        send_byte(w[23:16], 1'b0);
        send_byte(w[15:8], 1'b0);
        send_byte(w[7:0], last);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (headers_due.size() != 0);
    endtask

    function automatic bit [31:0] frame_word(bit [1:0] v, bit [1:0] l, bit prot, bit [15:0] tail);
        return {SYNC_BYTE, SYNC_TOP, v, l, prot, tail};
    endfunction

    // mostly short bodies, an occasional long one
    function automatic bit [31:0] make_frame_word(bit [1:0] v, bit [1:0] l);
        bit [31:0] w;
        bit [15:0] tail;
        int        tries;
        w = '0;
        for (tries = 0; tries < 8; tries++) begin
            tail = 16'($urandom);
            tail[15:12] = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(4));
            tail[11:10] = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
            w = frame_word(v, l, 1'($urandom_range(1)), tail);
            if (body_of(w) <= 96 || $urandom_range(24) == 0) return w;
        end
        return w;
    endfunction

    function automatic bit [7:0] noise_byte();
        case ($urandom_range(3))
            0:       return SYNC_BYTE;
            1:       return {SYNC_TOP, 5'($urandom_range(31))};
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bit [1:0] pick_ver();
        case ($urandom_range(9))
            0:       return VER_RES;
            1, 2, 3: return VER_25;
            4, 5, 6: return VER_2;
            default: return VER_1;
        endcase
    endfunction

    function automatic bit [1:0] pick_lay();
        case ($urandom_range(9))
            0:       return LAY_RES;
            1, 2, 3: return LAY_1;
            4, 5, 6: return LAY_2;
            default: return LAY_3;
        endcase
    endfunction

    // feed body bytes, long bodies get cut by a stream end
    task automatic drain_body();
        while (scan_st == ST_SKIP) begin
            if (skip_left > BIG_BODY && $urandom_range(7) == 0) send_byte(8'($urandom), 1'b1);
            else send_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic test_reserved_codes();
        send_hdr(frame_word(VER_RES, LAY_RES, 1'b0, 16'hFFFF), 1'b1);
        wait_drained();
    endtask

    task automatic test_saturated_body();
        send_hdr(frame_word(VER_1, LAY_1, 1'b1, 16'hEE00), 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic test_lock_mismatch();
        send_hdr(frame_word(VER_2, LAY_3, 1'b0, 16'h0000), 1'b0);
        send_hdr(frame_word(VER_1, LAY_3, 1'b1, 16'h0000), 1'b0);
        send_hdr(frame_word(VER_2, LAY_2, 1'b0, 16'h0200), 1'b0);
        send_hdr(frame_word(VER_2, LAY_3, 1'b0, 16'h0200), 1'b0);
        send_byte(SYNC_BYTE, 1'b0);
        send_byte(SYNC_BYTE, 1'b0);
        send_byte({SYNC_TOP, VER_2, LAY_3, 1'b0}, 1'b1);
        wait_drained();
    endtask

    task automatic test_output_stall();
        bit [15:0] tail;
        in_idle_pct = 0;
        send_byte(8'h00, 1'b1);
        rx_hold = 500;
        repeat (8) begin
            tail = 16'($urandom);
            tail[15:12] = 4'd0;
            tail[11:10] = 2'($urandom_range(2));
            tail[9] = 1'b0;
            send_hdr(frame_word(VER_1, LAY_2, 1'b1, tail), 1'b0);
        end
        wait_drained();
    endtask

    task automatic test_random_streams(input int live_goal);
        bit [1:0] v;
        bit [1:0] l;
        int       k;
        int       n_frames;
        while (n_live < live_goal) begin
            v = pick_ver();
            l = pick_lay();
            n_frames = $urandom_range(1, 12);
            repeat ($urandom_range(3)) send_byte(8'($urandom_range(254)), 1'b0);
            for (k = 0; k < n_frames && n_live < live_goal; k++) begin
                case ($urandom_range(19))
                    0, 1: repeat ($urandom_range(1, 6)) send_byte(noise_byte(), 1'b0);
                    2: send_hdr(make_frame_word(2'($urandom_range(3)), 2'($urandom_range(3))),
                                1'b0);
                    3: begin
                        send_byte(SYNC_BYTE, 1'b0);
                        send_byte({SYNC_TOP, 5'($urandom_range(31))}, $urandom_range(3) == 0);
                    end
                    default: send_hdr(make_frame_word(v, l), 1'b0);
                endcase
                drain_body();
            end
            send_byte(8'($urandom), 1'b1);
        end
        wait_drained();
    endtask

    initial begin
        clear_parser();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        in_idle_pct = 18;
        out_idle_pct = 60;
        test_reserved_codes();
        test_saturated_body();
        test_lock_mismatch();
        test_output_stall();

        in_idle_pct = 18;
        out_idle_pct = 60;
        test_random_streams(LIVE_TARGET / 3);
        in_idle_pct = 60;
        out_idle_pct = 18;
        test_random_streams(2 * LIVE_TARGET / 3);
        in_idle_pct = 0;
        out_idle_pct = 0;
        test_random_streams(LIVE_TARGET);

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (n_bad == 0 && headers_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
